FILE: design/stfm_pkg.sv
`default_nettype none
package stfm_pkg;

  localparam int BIN_W = 11;
  localparam int MAG_W = 16;
  localparam int TH_W  = 4;
  localparam int FH_W  = 5;
  localparam int CFG_W = 5;

  localparam logic CFG_TIME_SPAN = 1'b0;
  localparam logic CFG_FREQ_SPAN = 1'b1;

  typedef struct packed {
    logic clr;
    logic load;
    logic store;
    logic start_t;
    logic issue_t;
    logic start_f;
    logic issue_f;
    logic sort_clr;
    logic lat_t;
    logic lat_f;
    logic ld_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bin_ok;
    logic cnt_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/stfm_ctrl.sv
`default_nettype none
module stfm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire stfm_pkg::sts_t sts,
  output stfm_pkg::cmd_t     cmd,
  output logic               in_ready
);
  import stfm_pkg::*;

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_WR   = 9'b000000100,
    S_TRD  = 9'b000001000,
    S_TDR  = 9'b000010000,
    S_TLAT = 9'b000100000,
    S_FRD  = 9'b001000000,
    S_FDR  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        if (sts.bin_ok) begin
          cmd.store    = 1'b1;
          cmd.start_t  = 1'b1;
          cmd.sort_clr = 1'b1;
          state_nxt    = S_TRD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_TRD: begin
        cmd.issue_t = 1'b1;
        if (sts.cnt_last) state_nxt = S_TDR;
      end
      S_TDR: state_nxt = S_TLAT;
      S_TLAT: begin
        cmd.lat_t    = 1'b1;
        cmd.start_f  = 1'b1;
        cmd.sort_clr = 1'b1;
        state_nxt    = S_FRD;
      end
      S_FRD: begin
        cmd.issue_f = 1'b1;
        if (sts.cnt_last) state_nxt = S_FDR;
      end
      S_FDR: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
    if (state_r == S_OUT && sts.bin_ok && sts.out_free) cmd.lat_f = 1'b1;
  end

endmodule
`default_nettype wire

FILE: design/stfm_dp.sv
`default_nettype none
module stfm_dp #(
  parameter int BINS          = 1025,
  parameter int MAX_TIME_TAPS = 17,
  parameter int MAX_FREQ_TAPS = 33,
  parameter int MAG_BITS      = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire stfm_pkg::cmd_t           cmd,
  output stfm_pkg::sts_t                sts,
  input  wire logic                     cfg_wr_en,
  input  wire logic                     cfg_addr,
  input  wire logic [stfm_pkg::CFG_W-1:0] cfg_wr_data,
  input  wire logic [stfm_pkg::BIN_W-1:0] in_bin,
  input  wire logic [stfm_pkg::MAG_W-1:0] in_mag,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic [stfm_pkg::BIN_W-1:0]    out_bin,
  output logic [stfm_pkg::MAG_W-1:0]    out_tmed,
  output logic [stfm_pkg::MAG_W-1:0]    out_fmed,
  output logic                          out_last
);
  import stfm_pkg::*;

  localparam int T      = MAX_TIME_TAPS;
  localparam int RING   = T * BINS;
  localparam int AW     = $clog2(RING);
  localparam int SLW    = (T > 1) ? $clog2(T) : 1;
  localparam int LAG    = T / 2;
  localparam int TH_LIM = (T - 1) / 2;
  localparam int FH_LIM = (MAX_FREQ_TAPS - 1) / 2;
  localparam int SN     = (T > MAX_FREQ_TAPS) ? T : MAX_FREQ_TAPS;
  localparam int CW     = $clog2(SN + 1);
  localparam int SIW    = (SN > 1) ? $clog2(SN) : 1;
  localparam int SW     = (MAG_BITS < MAG_W) ? MAG_BITS : MAG_W;
  localparam int BW     = BIN_W + 3;

  logic [SW-1:0]     mem [RING];
  logic [SW-1:0]     mem_q_r;
  logic [AW-1:0]     clr_addr_r;
  logic [TH_W-1:0]   th_r;
  logic [FH_W-1:0]   fh_r;
  logic [BIN_W-1:0]  bin_r;
  logic [SW-1:0]     mag_r;
  logic [SLW-1:0]    slot_r;
  logic [SLW-1:0]    k_r;
  logic signed [BW-1:0] b_r;
  logic [CW-1:0]     cnt_r;
  logic              ins_v_r;
  logic              ins_zero_r;
  logic [SW-1:0]     s_r [SN];
  logic [SW-1:0]     s_nxt [SN];
  logic [CW-1:0]     n_r;
  logic [SW-1:0]     tmed_r;
  logic [SW-1:0]     fmed_r;
  logic              out_valid_r;
  logic [BIN_W-1:0]  out_bin_r;
  logic [SW-1:0]     out_tmed_r;
  logic [SW-1:0]     out_fmed_r;
  logic              out_last_r;

  logic [SLW:0]      centre_sum;
  logic [SLW-1:0]    centre;
  logic [SLW-1:0]    th_eff;
  logic [6:0]        fh_eff;
  logic [SLW:0]      kst_sum;
  logic [SLW-1:0]    kst;
  logic              bin_ok;
  logic              bin_last;
  logic              b_in;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [SW-1:0]     mem_wd;
  logic [SW-1:0]     ins_val;
  logic [SN-1:0]     gt;
  logic [SW-1:0]     med;

  assign bin_ok   = ({{(32-BIN_W){1'b0}}, bin_r} < 32'(BINS));
  assign bin_last = ({{(32-BIN_W){1'b0}}, bin_r} == 32'(BINS - 1));

  assign th_eff = ({28'd0, th_r} > 32'(TH_LIM)) ? SLW'(TH_LIM) : SLW'(th_r);
  assign fh_eff = ({27'd0, fh_r} > 32'(FH_LIM)) ? 7'(FH_LIM) : 7'(fh_r);

  assign centre_sum = (SLW+1)'(slot_r) + (SLW+1)'(T - LAG);
  assign centre     = (centre_sum >= (SLW+1)'(T)) ? SLW'(centre_sum - (SLW+1)'(T))
                                                   : SLW'(centre_sum);
  assign kst_sum    = (SLW+1)'(centre) + (SLW+1)'(T) - (SLW+1)'(th_eff);
  assign kst        = (kst_sum >= (SLW+1)'(T)) ? SLW'(kst_sum - (SLW+1)'(T))
                                               : SLW'(kst_sum);

  assign b_in = (b_r >= 0) && (b_r < BW'(BINS));

  always_comb begin
    mem_we   = 1'b0;
    mem_wd   = mag_r;
    mem_addr = AW'(k_r) * AW'(BINS) + AW'(bin_r);
    if (cmd.clr) begin
      mem_we   = 1'b1;
      mem_wd   = '0;
      mem_addr = clr_addr_r;
    end else if (cmd.store) begin
      mem_we   = 1'b1;
      mem_addr = AW'(slot_r) * AW'(BINS) + AW'(bin_r);
    end else if (cmd.issue_f) begin
      mem_addr = AW'(centre) * AW'(BINS) + AW'(b_r[BW-2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end else begin
      mem_q_r <= mem[mem_addr];
    end
  end

  assign ins_val = ins_zero_r ? '0 : mem_q_r;

  always_comb begin
    for (int i = 0; i < SN; i++) begin
      gt[i] = (CW'(i) >= n_r) || (ins_val < s_r[i]);
    end
    for (int i = 0; i < SN; i++) begin
      if (!gt[i]) begin
        s_nxt[i] = s_r[i];
      end else if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
        s_nxt[i] = s_r[(i > 0) ? i - 1 : 0];
      end else begin
        s_nxt[i] = ins_val;
      end
    end
  end

  assign med = s_r[SIW'(n_r >> 1)];

  always_ff @(posedge clk) begin
    if (ins_v_r) begin
      for (int i = 0; i < SN; i++) s_r[i] <= s_nxt[i];
    end
    if (cmd.load) begin
      bin_r <= in_bin;
      mag_r <= SW'(in_mag);
    end
    if (cmd.start_t) begin
      k_r   <= kst;
      cnt_r <= CW'({th_eff, 1'b1});
    end else if (cmd.start_f) begin
      b_r   <= BW'(bin_r) - BW'(fh_eff);
      cnt_r <= CW'({fh_eff, 1'b1});
    end else if (cmd.issue_t) begin
      k_r   <= (k_r == SLW'(T - 1)) ? '0 : k_r + SLW'(1);
      cnt_r <= cnt_r - CW'(1);
    end else if (cmd.issue_f) begin
      b_r   <= b_r + BW'(1);
      cnt_r <= cnt_r - CW'(1);
    end
    if (cmd.load) begin
      tmed_r <= '0;
      fmed_r <= '0;
    end
    if (cmd.lat_t) tmed_r <= med;
    if (cmd.ld_out) begin
      out_bin_r  <= bin_r;
      out_tmed_r <= tmed_r;
      out_fmed_r <= cmd.lat_f ? med : fmed_r;
      out_last_r <= bin_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      th_r        <= TH_W'(8);
      fh_r        <= FH_W'(4);
      slot_r      <= '0;
      ins_v_r     <= 1'b0;
      ins_zero_r  <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_addr_r <= clr_addr_r + AW'(1);
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_TIME_SPAN: th_r <= cfg_wr_data[TH_W-1:0];
          CFG_FREQ_SPAN: fh_r <= cfg_wr_data;
          default: ;
        endcase
      end
      ins_v_r    <= cmd.issue_t || cmd.issue_f;
      ins_zero_r <= cmd.issue_f && !b_in;
      if (cmd.sort_clr) begin
        n_r <= '0;
      end else if (ins_v_r) begin
        n_r <= n_r + CW'(1);
      end
      if (cmd.lat_f && bin_last) begin
        slot_r <= (slot_r == SLW'(T - 1)) ? '0 : slot_r + SLW'(1);
      end
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.clr_last = (clr_addr_r == AW'(RING - 1));
  assign sts.bin_ok   = bin_ok;
  assign sts.cnt_last = (cnt_r == CW'(1));
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_bin   = out_bin_r;
  assign out_tmed  = MAG_W'(out_tmed_r);
  assign out_fmed  = MAG_W'(out_fmed_r);
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

FILE: design/spectral_time_freq_median_unit.sv
`default_nettype none
// Time/frequency median filter over a ring of MAX_TIME_TAPS spectral frames of
// BINS bins. Each input word carries one bin magnitude; each output word gives,
// for the same bin of the frame MAX_TIME_TAPS/2 frames back, the median over
// 2*time_half_span+1 frames and over 2*freq_half_span+1 bins (outside bins count
// as zero). After reset a clearing pass writes zero into all MAX_TIME_TAPS*BINS
// ring words, one per cycle, with in_tready low. Input words are then taken one
// at a time, the single ring memory port reading one tap per cycle into an
// insertion sorter; an out-of-range bin skips the ring reads and the sort.
module spectral_time_freq_median_unit #(
  parameter int BINS          = 1025,
  parameter int MAX_TIME_TAPS = 17,
  parameter int MAX_FREQ_TAPS = 33,
  parameter int MAG_BITS      = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // bin_index, magnitude
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // out_bin, time_median, freq_median
  output logic             out_tlast,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_addr,
  input  wire logic [stfm_pkg::CFG_W-1:0] cfg_wr_data
);
  import stfm_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [BIN_W-1:0]   o_bin;
  logic [MAG_W-1:0]   o_tmed;
  logic [MAG_W-1:0]   o_fmed;

  stfm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_tvalid && in_tready),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_tready)
  );

  stfm_dp #(
    .BINS          (BINS),
    .MAX_TIME_TAPS (MAX_TIME_TAPS),
    .MAX_FREQ_TAPS (MAX_FREQ_TAPS),
    .MAG_BITS      (MAG_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .in_bin      (in_tdata[10:0]),
    .in_mag      (in_tdata[26:11]),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_bin     (o_bin),
    .out_tmed    (o_tmed),
    .out_fmed    (o_fmed),
    .out_last    (out_tlast)
  );

  assign out_tdata = {5'd0, o_fmed, o_tmed, o_bin};

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while busy");

  a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[10:0] == 11'(BINS - 1)))
    else $error("frame end on wrong bin");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken before ring clear");

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
module tb;
  import stfm_pkg::*;

  localparam int NBINS  = 1025;
  localparam int NSLOTS = 17;
  localparam int LAG    = NSLOTS / 2;
  localparam int TH_MAX = (NSLOTS - 1) / 2;
  localparam int FH_MAX = (33 - 1) / 2;

  typedef struct {
    logic [BIN_W-1:0] bin;
    logic [MAG_W-1:0] tmed;
    logic [MAG_W-1:0] fmed;
    logic             fend;
  } medians_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic cfg_addr = CFG_TIME_SPAN;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  logic [MAG_W-1:0] ring_model [NSLOTS*NBINS];
  int unsigned      write_slot;
  logic [TH_W-1:0]  th_model;
  logic [FH_W-1:0]  fh_model;
  medians_t         pending_medians [$];

  int  err_cnt = 0;
  int  words_in = 0;
  int  words_out = 0;
  int  frames_done = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic hold_off = 1'b0;
  event long_hold;

  spectral_time_freq_median_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [MAG_W-1:0] middle_of(logic [MAG_W-1:0] vals [$]);
    vals.sort();
    return vals[vals.size() / 2];
  endfunction

  task automatic predict_medians(input logic [BIN_W-1:0] bin, input logic [MAG_W-1:0] mag);
    medians_t r;
    logic [MAG_W-1:0] tv [$];
    logic [MAG_W-1:0] fv [$];
    int th, fh, centre, b;
    r.bin = bin;
    r.tmed = '0;
    r.fmed = '0;
    r.fend = 1'b0;
    if (bin < NBINS) begin
      ring_model[write_slot*NBINS + bin] = mag;
      th = (th_model > TH_MAX) ? TH_MAX : th_model;
      fh = (fh_model > FH_MAX) ? FH_MAX : fh_model;
      centre = (write_slot + NSLOTS - LAG) % NSLOTS;
      for (int d = -th; d <= th; d++)
        tv.push_back(ring_model[((centre + NSLOTS + d) % NSLOTS)*NBINS + bin]);
      for (int d = -fh; d <= fh; d++) begin
        b = int'(bin) + d;
        fv.push_back((b < 0 || b >= NBINS) ? '0 : ring_model[centre*NBINS + b]);
      end
      r.tmed = middle_of(tv);
      r.fmed = middle_of(fv);
      if (bin == NBINS - 1) begin
        r.fend = 1'b1;
        write_slot = (write_slot + 1) % NSLOTS;
        frames_done++;
      end
    end
    pending_medians.push_back(r);
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s at word %0d: got %0h want %0h", what, words_out, got, want);
    err_cnt++;
  endtask

  // sender: optional gap, then offer the word until it is taken
  task automatic send_bin(input logic [BIN_W-1:0] bin, input logic [MAG_W-1:0] mag);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, mag, bin};
    do @(posedge clk); while (!in_tready);
    predict_medians(bin, mag);
    words_in++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [CFG_W-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= addr;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (addr == CFG_TIME_SPAN) th_model = val[TH_W-1:0];
    else fh_model = val;
  endtask

  task automatic set_spans(input int th, input int fh);
    drain();
    write_reg(CFG_TIME_SPAN, CFG_W'(th));
    write_reg(CFG_FREQ_SPAN, CFG_W'(fh));
  endtask

  always @(posedge clk) begin
    out_tready <= hold_off ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      words_out++;
      if (pending_medians.size() == 0) begin
        report("unexpected word", int'(out_tdata[10:0]), 0);
      end else begin
        medians_t e;
        e = pending_medians.pop_front();
        if (out_tdata[10:0] != e.bin) report("out_bin", out_tdata[10:0], e.bin);
        if (out_tdata[26:11] != e.tmed) report("time_median", out_tdata[26:11], e.tmed);
        if (out_tdata[42:27] != e.fmed) report("freq_median", out_tdata[42:27], e.fmed);
        if (out_tdata[47:43] != 0) report("tdata pad", out_tdata[47:43], 0);
        if (out_tlast != e.fend) report("frame_end", out_tlast, e.fend);
      end
    end
  end

  initial forever begin
    @(long_hold);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic test_directed();
    send_bin(0, 16'h0000);
    send_bin(0, 16'hffff);
    send_bin(1, 16'h8001);
    send_bin(2, 16'h7ffe);
    send_bin(1023, 16'hffff);
    send_bin(1024, 16'hffff);
    send_bin(1025, 16'hffff);
    send_bin(11'h7ff, 16'h1234);
    send_bin(11'h555, 16'haaaa);
    send_bin(700, 16'h5555);
    send_bin(300, 16'h00ff);
    send_bin(1024, 16'h0001);
  endtask

  task automatic test_span_extremes();
    set_spans(0, 0);
    send_bin(0, 16'hffff);
    send_bin(512, 16'h0f0f);
    send_bin(1024, 16'hf0f0);
    set_spans(15, 31);
    send_bin(0, 16'h1111);
    send_bin(1, 16'hffff);
    send_bin(1024, 16'hffff);
    set_spans(TH_MAX, FH_MAX);
    send_bin(3, 16'h4321);
    send_bin(1020, 16'hfffe);
    send_bin(1024, 16'h0000);
  endtask

  // sparse frames: rising-bin clusters at fixed spots, mostly then the last bin
  task automatic run_frames(input int n_words);
    int base [3];
    int stop;
    base = '{0, 500, 1014};
    stop = words_in + n_words;
    while (words_in < stop) begin
      if ($urandom_range(9) == 0) begin
        send_bin(11'($urandom_range(2047)), 16'($urandom));
      end else begin
        for (int c = 0; c < 3; c++) begin
          if ($urandom_range(3) != 0) begin
            int len = $urandom_range(6, 1);
            for (int k = 0; k < len; k++)
              send_bin(11'(base[c] + k), ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom));
          end
        end
        if ($urandom_range(19) != 0) send_bin(1024, 16'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    -> long_hold;
    run_frames(60);
  endtask

  initial begin
    foreach (ring_model[i]) ring_model[i] = '0;
    write_slot = 0;
    th_model = 4'd8;
    fh_model = 5'd4;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_span_extremes();

    send_idle_pct = 30;
    recv_idle_pct = 79;
    set_spans(3, 16);
    run_frames(480);
    test_backpressure();

    send_idle_pct = 79;
    recv_idle_pct = 30;
    set_spans(8, 7);
    run_frames(480);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_spans(15, 31);
    run_frames(300);
    set_spans(1, 2);
    run_frames(200);

    drain();
    repeat (100) @(posedge clk);
    $display("Sent %0d words over %0d frames, checked %0d medians", words_in, frames_done,
             words_out);
    $display("Spans covered 0..15 and 0..31, idle mixes and a long output stall");
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: spectral_time_freq_median_unit.f
design/stfm_pkg.sv
design/stfm_ctrl.sv
design/stfm_dp.sv
design/spectral_time_freq_median_unit.sv
tb/tb.sv
